// ----- design/tcla_pkg.sv -----
// Package: widths, window constants and reciprocal constants for the level averager.
`timescale 1ns / 1ps

package tcla_pkg;

  localparam int LEVEL_W = 12;
  localparam int NUM_CH  = 3;
  localparam int WINDOW  = 20;

  localparam int WIN_LOG = $clog2(WINDOW);
  // Running sum stays exact: WINDOW * (2^LEVEL_W - 1) < 2^SUM_W
  localparam int SUM_W   = LEVEL_W + WIN_LOG;

  // sum / WINDOW == (sum * RECIP) >> RECIP_SHIFT for every sum < 2^SUM_W
  localparam int RECIP_SHIFT = SUM_W + WIN_LOG;
  localparam int RECIP_W     = SUM_W + 2;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int LONG_PROD_W = SUM_W + RECIP_W;

  // Sum of three short averages and its division by three
  localparam int TOTAL_W       = LEVEL_W + 2;
  localparam int THIRD_SHIFT   = TOTAL_W + 2;
  localparam int THIRD_RECIP_W = THIRD_SHIFT - 1;
  localparam longint unsigned THIRD_RECIP_L = ((64'd1 << THIRD_SHIFT) + 2) / 3;
  localparam logic [THIRD_RECIP_W-1:0] THIRD_RECIP = THIRD_RECIP_W'(THIRD_RECIP_L);
  localparam int THIRD_PROD_W  = TOTAL_W + THIRD_RECIP_W;

  localparam int IN_FIELDS_W  = NUM_CH * LEVEL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = (2 * NUM_CH + 1) * LEVEL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

// ----- design/tcla_channel.sv -----
// One channel: reading history shift line, running window sum and short average.
`timescale 1ns / 1ps

module tcla_channel
  import tcla_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_en,
  input  logic [LEVEL_W-1:0] level,
  output logic [SUM_W-1:0]   sum_nxt,
  output logic [LEVEL_W-1:0] short_avg
);

  // hist_r[0] is the newest stored reading, hist_r[WINDOW-1] the oldest
  logic [LEVEL_W-1:0] hist_r [WINDOW];
  logic [SUM_W-1:0]   sum_r;
  logic [LEVEL_W:0]   pair_sum;

  assign sum_nxt   = sum_r - SUM_W'(hist_r[WINDOW-1]) + SUM_W'(level);
  assign pair_sum  = {1'b0, level} + {1'b0, hist_r[0]};
  assign short_avg = pair_sum[LEVEL_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        hist_r[i] <= '0;
      end
    end else if (beat_en) begin
      sum_r     <= sum_nxt;
      hist_r[0] <= level;
      for (int i = 1; i < WINDOW; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

endmodule

// ----- design/three_channel_level_averager.sv -----
// Top level: three-channel moving-average filter for microphone level readings.
`timescale 1ns / 1ps

// Takes one beat per clock carrying a 12-bit reading for each of three
// microphones and returns one beat per input beat, in order: per channel
// the truncated mean of the last WINDOW readings (running sum, zeros after
// reset count as readings), the truncated mean of the newest two readings,
// and the truncated mean of those three short averages. Sustained rate is
// one beat per cycle without backpressure. Stage one registers the updated
// running sums and short averages, then stage two divides by WINDOW and by
// three through constant reciprocal multiplies into the output register.
// Backpressure on the output stalls the pipeline only once both stages hold.

module three_channel_level_averager
  import tcla_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // level_mic0, level_mic1, level_mic2
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // long_avg_mic0..2, short_avg_mic0..2, short_avg_overall, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_fire;
  logic out_ld;

  logic [SUM_W-1:0]   sum_nxt   [NUM_CH];
  logic [LEVEL_W-1:0] short_nxt [NUM_CH];
  logic [TOTAL_W-1:0] total_nxt;

  logic               s1_valid_r;
  logic [SUM_W-1:0]   s1_sum_r   [NUM_CH];
  logic [LEVEL_W-1:0] s1_short_r [NUM_CH];
  logic [TOTAL_W-1:0] s1_total_r;

  logic                    out_valid_r;
  logic [LONG_PROD_W-1:0]  out_long_prod_r [NUM_CH];
  logic [LEVEL_W-1:0]      out_short_r     [NUM_CH];
  logic [THIRD_PROD_W-1:0] out_third_prod_r;

  assign out_ld    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_ld;
  assign in_fire   = in_tvalid && in_tready;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    tcla_channel u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .beat_en   (in_fire),
      .level     (in_tdata[c*LEVEL_W +: LEVEL_W]),
      .sum_nxt   (sum_nxt[c]),
      .short_avg (short_nxt[c])
    );
  end

  assign total_nxt = TOTAL_W'(short_nxt[0]) + TOTAL_W'(short_nxt[1])
                   + TOTAL_W'(short_nxt[2]);

  // stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (out_ld) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sum_r   <= sum_nxt;
      s1_short_r <= short_nxt;
      s1_total_r <= total_nxt;
    end
  end

  // stage two: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && s1_valid_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_long_prod_r[c] <= LONG_PROD_W'(s1_sum_r[c]) * LONG_PROD_W'(RECIP);
      end
      out_short_r      <= s1_short_r;
      out_third_prod_r <= THIRD_PROD_W'(s1_total_r) * THIRD_PROD_W'(THIRD_RECIP);
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      out_tdata[c*LEVEL_W +: LEVEL_W] = out_long_prod_r[c][RECIP_SHIFT +: LEVEL_W];
      out_tdata[(NUM_CH+c)*LEVEL_W +: LEVEL_W] = out_short_r[c];
    end
    out_tdata[2*NUM_CH*LEVEL_W +: LEVEL_W] = out_third_prod_r[THIRD_SHIFT +: LEVEL_W];
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- design/tcla_checker.sv -----
// Port checker for the level averager and its bind.
`timescale 1ns / 1ps

module tcla_checker
  import tcla_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [LEVEL_W-1:0] sh0, sh1, sh2, ovr;

  assign sh0 = out_tdata[NUM_CH*LEVEL_W +: LEVEL_W];
  assign sh1 = out_tdata[(NUM_CH+1)*LEVEL_W +: LEVEL_W];
  assign sh2 = out_tdata[(NUM_CH+2)*LEVEL_W +: LEVEL_W];
  assign ovr = out_tdata[2*NUM_CH*LEVEL_W +: LEVEL_W];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_beat_arrives: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted beat did not reach the output");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_overall_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ovr <= sh0 || ovr <= sh1 || ovr <= sh2)
                && (ovr >= sh0 || ovr >= sh1 || ovr >= sh2))
    else $error("overall short average outside channel range");

endmodule

bind three_channel_level_averager tcla_checker u_tcla_checker (.*);

// ----- verif/tb_three_channel_level_averager.sv -----
// Testbench: three_channel_level_averager stream checked beat by beat against an in-bench predictor.
`timescale 1ns / 1ps

module tb_three_channel_level_averager;
  import tcla_pkg::*;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t [NUM_CH-1:0] long_avg;
    level_t [NUM_CH-1:0] short_avg;
    level_t              overall;
  } averages_t;

  typedef struct packed {
    level_t mic0;
    level_t mic1;
    level_t mic2;
    bit     fixed;
    level_t long_all;
    level_t short_all;
    level_t overall;
  } level_row_t;

  localparam int DIR_ROWS     = 13;
  localparam int RANDOM_ITEMS = 400;
  localparam int CHOKE_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam level_t LVL_MAX  = level_t'((1 << LEVEL_W) - 1);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // expected averages for the two full-scale beats after reset, then a zero beat
  level_row_t level_rows [DIR_ROWS] = '{
    '{12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd204, 12'd2047, 12'd2047},
    '{12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd409, 12'd4095, 12'd4095},
    '{12'd0,    12'd0,    12'd0,    1'b1, 12'd409, 12'd2047, 12'd2047},
    '{12'd1,    12'd2,    12'd3,    1'b0, 12'd0,   12'd0,    12'd0},
    '{12'hAAA,  12'h555,  12'hAAA,  1'b0, 12'd0,   12'd0,    12'd0},
    '{12'h555,  12'hAAA,  12'h555,  1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd4095, 12'd0,    12'd4095, 1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd0,    12'd4095, 12'd0,    1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd1,    12'd1,    12'd1,    1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd2048, 12'd2047, 12'd1,    1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd4094, 12'd4095, 12'd4093, 1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd0,    12'd1,    12'd0,    1'b0, 12'd0,   12'd0,    12'd0},
    '{12'd0,    12'd0,    12'd0,    1'b0, 12'd0,   12'd0,    12'd0}
  };

  level_t      level_history [NUM_CH][WINDOW];
  int unsigned level_sums [NUM_CH];
  int unsigned write_slot;

  averages_t pending_averages [$];
  averages_t want_avg;
  averages_t got_avg;

  int  errors = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  bit  choke_req = 1'b0;

  three_channel_level_averager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void clear_history();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      level_sums[ch] = 0;
      for (int i = 0; i < WINDOW; i++) level_history[ch][i] = '0;
    end
    write_slot = 0;
  endfunction

  function automatic averages_t advance_averages(input level_t [NUM_CH-1:0] fresh);
    averages_t   res;
    int unsigned prev_slot;
    int unsigned shorts_total;
    int unsigned pair_avg;
    level_t      prev;
    level_t      oldest;
    shorts_total = 0;
    prev_slot = (write_slot + WINDOW - 1) % WINDOW;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prev   = level_history[ch][prev_slot];
      oldest = level_history[ch][write_slot];
      level_sums[ch] = level_sums[ch] - oldest + fresh[ch];
      level_history[ch][write_slot] = fresh[ch];
      pair_avg = (32'(fresh[ch]) + 32'(prev)) / 2;
      shorts_total += pair_avg;
      res.long_avg[ch]  = level_t'(level_sums[ch] / WINDOW);
      res.short_avg[ch] = level_t'(pair_avg);
    end
    res.overall = level_t'(shorts_total / 3);
    write_slot = (write_slot + 1) % WINDOW;
    return res;
  endfunction

  // mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 99) < 60) return 0;
    return pick_gap();
  endfunction

  task automatic send_levels(input level_t [NUM_CH-1:0] lv, input int gap,
                             input bit use_fixed, input averages_t fixed);
    averages_t predicted;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(lv);
    do @(posedge clk); while (!in_tready);
    predicted = advance_averages(lv);
    pending_averages.push_back(use_fixed ? fixed : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (choke_req) begin
        out_tready <= 1'b0;
        stall_left = CHOKE_CYCLES;
        choke_req  = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_averages.size() == 0) begin
        $error("result beat with no expectation waiting: %h", out_tdata);
        errors++;
      end else begin
        want_avg = pending_averages.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
          got_avg.long_avg[ch]  = out_tdata[ch*LEVEL_W +: LEVEL_W];
          got_avg.short_avg[ch] = out_tdata[(NUM_CH+ch)*LEVEL_W +: LEVEL_W];
        end
        got_avg.overall = out_tdata[2*NUM_CH*LEVEL_W +: LEVEL_W];
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (got_avg.long_avg[ch] !== want_avg.long_avg[ch]) begin
            $error("long_avg_mic%0d: expected %0d, got %0d", ch,
                   want_avg.long_avg[ch], got_avg.long_avg[ch]);
            errors++;
          end
          if (got_avg.short_avg[ch] !== want_avg.short_avg[ch]) begin
            $error("short_avg_mic%0d: expected %0d, got %0d", ch,
                   want_avg.short_avg[ch], got_avg.short_avg[ch]);
            errors++;
          end
        end
        if (got_avg.overall !== want_avg.overall) begin
          $error("short_avg_overall: expected %0d, got %0d",
                 want_avg.overall, got_avg.overall);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    level_t [NUM_CH-1:0] lv;
    averages_t           fixed;
    int                  mode;
    int                  burst;
    int                  random_sent;
    level_t              run_level;
    bit                  choke_done;
    bit                  pause_done;
    clear_history();
    random_sent = 0;
    choke_done  = 1'b0;
    pause_done  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    calm = 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      lv = {level_rows[r].mic2, level_rows[r].mic1, level_rows[r].mic0};
      fixed.long_avg  = {NUM_CH{level_rows[r].long_all}};
      fixed.short_avg = {NUM_CH{level_rows[r].short_all}};
      fixed.overall   = level_rows[r].overall;
      send_levels(lv, (r < 3) ? 0 : $urandom_range(0, 2), level_rows[r].fixed, fixed);
    end

    while (random_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 3);
      burst = (mode == 1) ? $urandom_range(WINDOW, WINDOW + 10) : $urandom_range(10, 40);
      run_level = ($urandom_range(0, 2) == 0) ? level_t'($urandom_range(0, LVL_MAX))
                : ($urandom_range(0, 1) ? LVL_MAX : level_t'(0));

      if (!choke_done && random_sent >= 120) begin
        choke_done = 1'b1;
        choke_req  = 1'b1;
        calm  = 1'b1;
        mode  = 0;
        burst = 40;
      end
      if (!pause_done && random_sent >= 280) begin
        pause_done = 1'b1;
        @(negedge clk);
        in_tvalid <= 1'b0;
        drain_results();
      end

      repeat (burst) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          case (mode)
            0: lv[ch] = level_t'($urandom_range(0, LVL_MAX));
            1: lv[ch] = run_level;
            2: lv[ch] = $urandom_range(0, 1) ? LVL_MAX : level_t'(0);
            default: lv[ch] = level_t'($urandom_range(0, 7));
          endcase
        end
        send_levels(lv, (choke_done && choke_req) ? 0 : sender_gap(), 1'b0, fixed);
        random_sent++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_averages.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
